[rtl/sbue_pkg.sv]
// Shared types, codes and sizing constants for the serial block upload engine.
`default_nettype none

package sbue_pkg;

  // Block buffer sizing
  localparam int BLOCK_BYTES = 512;
  localparam int BUF_AW      = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);

  // Frame header: 0x80, 4 length bytes, 0x90, 0x80, 4 address bytes, 0xA0
  localparam int HDR_LEN = 12;
  localparam int POS_W   = $clog2(BLOCK_BYTES + HDR_LEN + 1);

  // Jump frame: 0x80, 4 address bytes, 0xB1
  localparam int JUMP_LAST = 5;

  // Output queue behind the buffer read stage
  localparam int Q_DEPTH = 3;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_START_ADDRESS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_RETRIES = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CRC_RETRIES   = 2'd2;

  localparam logic [31:0] START_ADDRESS_RST = 32'h8000_0000;
  localparam logic [3:0]  BLOCK_RETRIES_RST = 4'd5;
  localparam logic [3:0]  CRC_RETRIES_RST   = 4'd4;

  // Operation codes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RECV    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;
  localparam logic [1:0] OP_SLOT    = 2'd3;

  // Phase codes; all but jump equal the reported status
  localparam logic [2:0] PH_LOAD   = 3'd0;
  localparam logic [2:0] PH_SEND   = 3'd1;
  localparam logic [2:0] PH_WAIT   = 3'd2;
  localparam logic [2:0] PH_ACCEPT = 3'd3;
  localparam logic [2:0] PH_FAIL   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_JUMP   = 3'd6;

  // Frame marker bytes
  localparam logic [7:0] MK_START = 8'h80;
  localparam logic [7:0] MK_LEN   = 8'h90;
  localparam logic [7:0] MK_DATA  = 8'hA0;
  localparam logic [7:0] MK_CRC   = 8'h81;
  localparam logic [7:0] MK_JUMP  = 8'hB1;

  typedef struct packed {
    logic [31:0] start_address;
    logic [3:0]  block_retries;
    logic [3:0]  crc_retries;
  } cfg_t;

  // One result as it leaves the control stage; data bytes come from the buffer
  typedef struct packed {
    logic       tx_valid;
    logic       use_buf;
    logic [7:0] tx_byte;
    logic [2:0] status;
  } entry_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [2:0] status;
  } result_t;

  // Byte idx of v, idx 0 is the most significant
  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = v[31:24];
      2'd1:    b = v[23:16];
      2'd2:    b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [3:0] at_least_one(input logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

endpackage

`default_nettype wire

[rtl/serial_block_upload_engine_unit.sv]
// Top level of the serial block upload engine.
`default_nettype none

// Serial block upload engine. Each request carries one operation (load a
// program byte, a received byte, a receive timeout or a transmit slot) and
// yields exactly one result (tx_valid, tx_byte, status). One request is taken
// every clock cycle while item_ready grants credit; a result passes the read
// stage register and the result queue, where up to three results wait while
// the result side stalls. The 512-entry byte block buffer has no clearing
// pass: only entries written for the current block are ever sent. Registers
// at byte address 0 (start address), 4 (block retries) and 8 (checksum
// retries) must be written over the APB port only while no request is in
// flight, a rule the block does not enforce; a zero retry count acts as one.
module serial_block_upload_engine_unit
  import sbue_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [1:0]         operation,
  input  wire logic [7:0]         data_byte,
  input  wire logic               end_of_block,
  input  wire logic               end_of_file,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic                    tx_valid,
  output logic      [7:0]         tx_byte,
  output logic      [2:0]         status
);

  cfg_t              cfg;
  entry_t            entry;
  logic              accept;
  logic              buf_wr_en, buf_rd_en;
  logic [BUF_AW-1:0] buf_wr_addr, buf_rd_addr;
  logic [7:0]        buf_wr_data, buf_rd_data;

  assign accept = item_valid && item_ready;

  sbue_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbue_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operation    (operation),
    .data_byte    (data_byte),
    .end_of_block (end_of_block),
    .end_of_file  (end_of_file),
    .cfg          (cfg),
    .buf_wr_en    (buf_wr_en),
    .buf_wr_addr  (buf_wr_addr),
    .buf_wr_data  (buf_wr_data),
    .buf_rd_en    (buf_rd_en),
    .buf_rd_addr  (buf_rd_addr),
    .entry        (entry)
  );

  // block buffer; loads and sends never touch it in the same cycle
  sbue_ram #(
    .WIDTH (8),
    .DEPTH (BLOCK_BYTES)
  ) u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (buf_wr_addr),
    .wr_data (buf_wr_data),
    .rd_en   (buf_rd_en),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  sbue_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .entry        (entry),
    .buf_rd_data  (buf_rd_data),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .tx_valid     (tx_valid),
    .tx_byte      (tx_byte),
    .status       (status)
  );

endmodule

`default_nettype wire

[rtl/sbue_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sbue_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/sbue_regs.sv]
// APB configuration registers of the serial block upload engine.
`default_nettype none

module sbue_regs
  import sbue_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_address <= START_ADDRESS_RST;
      cfg.block_retries <= BLOCK_RETRIES_RST;
      cfg.crc_retries   <= CRC_RETRIES_RST;
    end else if (wr) begin
      if (idx == REG_START_ADDRESS) cfg.start_address <= pwdata;
      if (idx == REG_BLOCK_RETRIES) cfg.block_retries <= pwdata[3:0];
      if (idx == REG_CRC_RETRIES)   cfg.crc_retries   <= pwdata[3:0];
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_START_ADDRESS: prdata = cfg.start_address;
      REG_BLOCK_RETRIES: prdata = {28'd0, cfg.block_retries};
      REG_CRC_RETRIES:   prdata = {28'd0, cfg.crc_retries};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/sbue_ctrl.sv]
// Control stage: phase sequencer, checksum, retry counters and buffer access.
`default_nettype none

module sbue_ctrl
  import sbue_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [1:0]        operation,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_block,
  input  wire logic              end_of_file,
  input  cfg_t                   cfg,
  output logic                   buf_wr_en,
  output logic      [BUF_AW-1:0] buf_wr_addr,
  output logic      [7:0]        buf_wr_data,
  output logic                   buf_rd_en,
  output logic      [BUF_AW-1:0] buf_rd_addr,
  output entry_t                 entry
);

  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [31:0]       file_offset, file_offset_next;
  logic [31:0]       running_sum, running_sum_next;
  logic [2:0]        phase, phase_next;
  logic [POS_W-1:0]  send_position, send_position_next;
  logic [31:0]       received_sum, received_sum_next;
  logic [2:0]        received_count, received_count_next;
  logic [3:0]        block_tries_left, block_tries_left_next;
  logic [3:0]        crc_tries_left, crc_tries_left_next;
  logic              final_block, final_block_next;

  logic [FILL_W-1:0] fill_inc;
  logic              fill_room;
  logic [POS_W-1:0]  frame_end;
  logic [POS_W-1:0]  data_idx;
  logic              in_data;
  logic [POS_W-1:0]  pos_m1, pos_p1;
  logic [31:0]       addr;
  logic [31:0]       rsum_new;
  logic [2:0]        rcnt_new;
  logic [3:0]        block_dec, crc_dec;
  logic [7:0]        hdr_byte;

  // shared datapath terms
  assign fill_inc  = fill_count + FILL_W'(1);
  assign fill_room = fill_count < FILL_W'(BLOCK_BYTES);
  assign frame_end = POS_W'(HDR_LEN) + POS_W'(fill_count);
  assign data_idx  = send_position - POS_W'(HDR_LEN);
  assign in_data   = (send_position >= POS_W'(HDR_LEN)) && (data_idx < POS_W'(fill_count));
  assign pos_m1    = send_position - POS_W'(1);
  assign pos_p1    = send_position + POS_W'(1);
  assign addr      = cfg.start_address + file_offset;
  assign rsum_new  = {received_sum[23:0], data_byte};
  assign rcnt_new  = received_count + 3'd1;
  assign block_dec = (block_tries_left == 4'd0) ? 4'd0 : block_tries_left - 4'd1;
  assign crc_dec   = (crc_tries_left == 4'd0) ? 4'd0 : crc_tries_left - 4'd1;

  // block frame header byte at the current position
  always_comb begin
    priority if (send_position == POS_W'(0)) begin
      hdr_byte = MK_START;
    end else if (send_position <= POS_W'(4)) begin
      hdr_byte = be_byte(32'(fill_count), pos_m1[1:0]);
    end else if (send_position == POS_W'(5)) begin
      hdr_byte = MK_LEN;
    end else if (send_position == POS_W'(6)) begin
      hdr_byte = MK_START;
    end else if (send_position <= POS_W'(10)) begin
      // positions 7..10 map to address bytes 0..3
      hdr_byte = be_byte(addr, pos_p1[1:0]);
    end else if (send_position == POS_W'(11)) begin
      hdr_byte = MK_DATA;
    end else begin
      hdr_byte = MK_CRC;
    end
  end

  // next state and result
  always_comb begin
    fill_count_next       = fill_count;
    file_offset_next      = file_offset;
    running_sum_next      = running_sum;
    phase_next            = phase;
    send_position_next    = send_position;
    received_sum_next     = received_sum;
    received_count_next   = received_count;
    block_tries_left_next = block_tries_left;
    crc_tries_left_next   = crc_tries_left;
    final_block_next      = final_block;
    buf_wr_en             = 1'b0;
    buf_wr_addr           = fill_count[BUF_AW-1:0];
    buf_wr_data           = data_byte;
    buf_rd_en             = 1'b0;
    buf_rd_addr           = data_idx[BUF_AW-1:0];
    entry.tx_valid        = 1'b0;
    entry.use_buf         = 1'b0;
    entry.tx_byte         = 8'd0;

    if (accept) begin
      unique case (operation)
        OP_LOAD: begin
          if (phase == PH_LOAD || phase == PH_ACCEPT) begin
            phase_next = PH_LOAD;
            if (fill_room) begin
              buf_wr_en        = 1'b1;
              fill_count_next  = fill_inc;
              running_sum_next = {running_sum[30:0], running_sum[31]} + 32'(data_byte);
            end
            // block complete: explicit end or buffer full
            if (end_of_block || end_of_file || !fill_room ||
                fill_inc >= FILL_W'(BLOCK_BYTES)) begin
              final_block_next      = end_of_file;
              block_tries_left_next = at_least_one(cfg.block_retries);
              phase_next            = PH_SEND;
              send_position_next    = '0;
              crc_tries_left_next   = at_least_one(cfg.crc_retries);
            end
          end
        end
        OP_RECV: begin
          if (phase == PH_WAIT) begin
            received_sum_next   = rsum_new;
            received_count_next = rcnt_new;
            if (rcnt_new >= 3'd4) begin
              received_count_next = 3'd0;
              if (rsum_new == running_sum) begin
                if (final_block) begin
                  phase_next         = PH_JUMP;
                  send_position_next = '0;
                end else begin
                  phase_next       = PH_ACCEPT;
                  file_offset_next = file_offset + 32'(fill_count);
                  fill_count_next  = '0;
                  running_sum_next = '0;
                end
              end else begin
                // checksum mismatch: resend the block or give up
                block_tries_left_next = block_dec;
                if (block_dec != 4'd0) begin
                  phase_next          = PH_SEND;
                  send_position_next  = '0;
                  crc_tries_left_next = at_least_one(cfg.crc_retries);
                end else begin
                  phase_next = PH_FAIL;
                end
              end
            end
          end
        end
        OP_TIMEOUT: begin
          if (phase == PH_WAIT) begin
            crc_tries_left_next = crc_dec;
            if (crc_dec != 4'd0) begin
              // request the checksum again
              phase_next         = PH_SEND;
              send_position_next = frame_end;
            end else begin
              block_tries_left_next = block_dec;
              if (block_dec != 4'd0) begin
                phase_next          = PH_SEND;
                send_position_next  = '0;
                crc_tries_left_next = at_least_one(cfg.crc_retries);
              end else begin
                phase_next = PH_FAIL;
              end
            end
          end
        end
        OP_SLOT: begin
          if (phase == PH_SEND) begin
            entry.tx_valid = 1'b1;
            if (in_data) begin
              entry.use_buf = 1'b1;
              buf_rd_en     = 1'b1;
            end else begin
              entry.tx_byte = hdr_byte;
            end
            if (send_position >= frame_end) begin
              phase_next          = PH_WAIT;
              received_sum_next   = '0;
              received_count_next = 3'd0;
            end else begin
              send_position_next = pos_p1;
            end
          end else if (phase == PH_JUMP) begin
            entry.tx_valid = 1'b1;
            priority if (send_position == POS_W'(0)) begin
              entry.tx_byte = MK_START;
            end else if (send_position <= POS_W'(4)) begin
              entry.tx_byte = be_byte(cfg.start_address, pos_m1[1:0]);
            end else begin
              entry.tx_byte = MK_JUMP;
            end
            if (send_position >= POS_W'(JUMP_LAST)) begin
              phase_next = PH_DONE;
            end else begin
              send_position_next = pos_p1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    entry.status = (phase_next == PH_JUMP) ? PH_SEND : phase_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count       <= '0;
      file_offset      <= '0;
      running_sum      <= '0;
      phase            <= PH_LOAD;
      send_position    <= '0;
      received_sum     <= '0;
      received_count   <= '0;
      block_tries_left <= '0;
      crc_tries_left   <= '0;
      final_block      <= 1'b0;
    end else begin
      fill_count       <= fill_count_next;
      file_offset      <= file_offset_next;
      running_sum      <= running_sum_next;
      phase            <= phase_next;
      send_position    <= send_position_next;
      received_sum     <= received_sum_next;
      received_count   <= received_count_next;
      block_tries_left <= block_tries_left_next;
      crc_tries_left   <= crc_tries_left_next;
      final_block      <= final_block_next;
    end
  end

endmodule

`default_nettype wire

[rtl/sbue_outq.sv]
// Buffer read stage and result queue; sets request credit toward the input.
`default_nettype none

module sbue_outq
  import sbue_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  entry_t          entry,
  input  wire logic [7:0] buf_rd_data,
  output logic            item_ready,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic            tx_valid,
  output logic [7:0]      tx_byte,
  output logic [2:0]      status
);

  logic              s1_valid;
  entry_t            s1;
  result_t           q_mem [Q_DEPTH];
  result_t           q_in;
  result_t           q_head;
  logic [Q_AW-1:0]   head, tail;
  logic [Q_CW-1:0]   count, count_next;
  logic              pop;
  logic [Q_CW:0]     in_flight;

  // read stage register; buffer data arrives together with the registered request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1 <= entry;
    end
  end

  assign q_in.tx_valid = s1.tx_valid;
  assign q_in.tx_byte  = s1.use_buf ? buf_rd_data : s1.tx_byte;
  assign q_in.status   = s1.status;

  // credit: requests in flight never exceed the queue depth
  assign in_flight  = (Q_CW + 1)'(count) + (Q_CW + 1)'(s1_valid);
  assign item_ready = in_flight < (Q_CW + 1)'(Q_DEPTH);

  assign pop        = result_valid && result_ready;
  assign count_next = count + Q_CW'(s1_valid) - Q_CW'(pop);

  // queue storage
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_mem[tail] <= q_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (s1_valid) begin
        tail <= (tail == Q_AW'(Q_DEPTH - 1)) ? '0 : tail + Q_AW'(1);
      end
      if (pop) begin
        head <= (head == Q_AW'(Q_DEPTH - 1)) ? '0 : head + Q_AW'(1);
      end
    end
  end

  assign q_head       = q_mem[head];
  assign result_valid = count != '0;
  assign tx_valid     = q_head.tx_valid;
  assign tx_byte      = q_head.tx_byte;
  assign status       = q_head.status;

endmodule

`default_nettype wire

[rtl/sbue_checker.sv]
// Port-level checks for the serial block upload engine, bound to the top level.
`default_nettype none

module sbue_checker
  import sbue_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_ready,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire logic       tx_valid,
  input wire logic [7:0] tx_byte,
  input wire logic [2:0] status
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(tx_valid) &&
      $stable(tx_byte) && $stable(status))
    else $error("stalled result changed");

  // the block takes requests right after reset
  a_ready_after_rst: assert property (@(posedge clk) rst |=> item_ready)
    else $error("not ready after reset");

  // idle slot sends a zero byte
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !tx_valid |-> tx_byte == 8'd0)
    else $error("idle slot with nonzero byte");

  // a transmitted byte only goes with sending, awaiting or jump-sent status
  a_tx_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && tx_valid |->
      status == PH_SEND || status == PH_WAIT || status == PH_DONE)
    else $error("transmit with wrong status");

  // status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status <= PH_DONE)
    else $error("status out of range");

endmodule

bind serial_block_upload_engine_unit sbue_checker u_sbue_checker (.*);

`default_nettype wire

[test/serial_block_upload_engine_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench: predicted upload frames and status against the upload engine.

import sbue_pkg::*;

// Tracks the loader state per request and holds the results still owed by the DUT
class upload_scoreboard;
  // register copies
  logic [31:0] start_reg;
  logic [3:0]  blk_retry_reg;
  logic [3:0]  crc_retry_reg;
  // engine state as predicted
  logic [7:0]  block_mem [BLOCK_BYTES];
  int          fill_cnt;
  logic [31:0] file_off;
  logic [31:0] block_sum;
  logic [2:0]  phase_now;
  int          send_pos;
  logic [31:0] rx_sum;
  int          rx_cnt;
  logic [3:0]  block_tries;
  logic [3:0]  crc_tries;
  bit          last_blk;
  result_t     pending_results[$];
  int          errors;

  function new();
    start_reg     = START_ADDRESS_RST;
    blk_retry_reg = BLOCK_RETRIES_RST;
    crc_retry_reg = CRC_RETRIES_RST;
    fill_cnt      = 0;
    file_off      = '0;
    block_sum     = '0;
    phase_now     = PH_LOAD;
    send_pos      = 0;
    rx_sum        = '0;
    rx_cnt        = 0;
    block_tries   = '0;
    crc_tries     = '0;
    last_blk      = 0;
    errors        = 0;
  endfunction

  // k = 0 picks the most significant byte
  function logic [7:0] msb_byte(logic [31:0] v, int k);
    return 8'(v >> (8 * (3 - k)));
  endfunction

  function logic [3:0] one_or_more(logic [3:0] v);
    return (v == 4'd0) ? 4'd1 : v;
  endfunction

  function void open_frame();
    phase_now = PH_SEND;
    send_pos  = 0;
    crc_tries = one_or_more(crc_retry_reg);
  endfunction

  function void count_bad_sum();
    if (block_tries > 0) block_tries--;
    if (block_tries > 0) open_frame();
    else phase_now = PH_FAIL;
  endfunction

  function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
    case (idx)
      REG_START_ADDRESS: start_reg = v;
      REG_BLOCK_RETRIES: blk_retry_reg = v[3:0];
      REG_CRC_RETRIES:   crc_retry_reg = v[3:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  // Advance the predicted state by one accepted request
  function void note_request(logic [1:0] op, logic [7:0] b, logic eob, logic eof);
    result_t     r;
    logic [31:0] addr;
    r = '0;
    case (op)
      OP_LOAD: begin
        if (phase_now == PH_LOAD || phase_now == PH_ACCEPT) begin
          phase_now = PH_LOAD;
          if (fill_cnt < BLOCK_BYTES) begin
            block_mem[fill_cnt] = b;
            fill_cnt++;
            block_sum = {block_sum[30:0], block_sum[31]} + {24'd0, b};
          end
          if (eob || eof || fill_cnt >= BLOCK_BYTES) begin
            last_blk    = eof;
            block_tries = one_or_more(blk_retry_reg);
            open_frame();
          end
        end
      end
      OP_RECV: begin
        if (phase_now == PH_WAIT) begin
          rx_sum = {rx_sum[23:0], b};
          rx_cnt++;
          if (rx_cnt >= 4) begin
            rx_cnt = 0;
            if (rx_sum == block_sum) begin
              if (last_blk) begin
                phase_now = PH_JUMP;
                send_pos  = 0;
              end else begin
                phase_now = PH_ACCEPT;
                file_off  = file_off + 32'(fill_cnt);
                fill_cnt  = 0;
                block_sum = '0;
              end
            end else begin
              count_bad_sum();
            end
          end
        end
      end
      OP_TIMEOUT: begin
        if (phase_now == PH_WAIT) begin
          if (crc_tries > 0) crc_tries--;
          if (crc_tries > 0) begin
            phase_now = PH_SEND;
            send_pos  = HDR_LEN + fill_cnt;
          end else begin
            count_bad_sum();
          end
        end
      end
      default: begin
        if (phase_now == PH_SEND) begin
          addr       = start_reg + file_off;
          r.tx_valid = 1'b1;
          if (send_pos == 0)       r.tx_byte = MK_START;
          else if (send_pos <= 4)  r.tx_byte = msb_byte(32'(fill_cnt), send_pos - 1);
          else if (send_pos == 5)  r.tx_byte = MK_LEN;
          else if (send_pos == 6)  r.tx_byte = MK_START;
          else if (send_pos <= 10) r.tx_byte = msb_byte(addr, send_pos - 7);
          else if (send_pos == 11) r.tx_byte = MK_DATA;
          else if (send_pos - HDR_LEN < fill_cnt) r.tx_byte = block_mem[send_pos - HDR_LEN];
          else r.tx_byte = MK_CRC;
          if (send_pos >= HDR_LEN + fill_cnt) begin
            phase_now = PH_WAIT;
            rx_sum    = '0;
            rx_cnt    = 0;
          end else begin
            send_pos++;
          end
        end else if (phase_now == PH_JUMP) begin
          r.tx_valid = 1'b1;
          if (send_pos == 0)      r.tx_byte = MK_START;
          else if (send_pos <= 4) r.tx_byte = msb_byte(start_reg, send_pos - 1);
          else r.tx_byte = MK_JUMP;
          if (send_pos >= JUMP_LAST) phase_now = PH_DONE;
          else send_pos++;
        end
      end
    endcase
    r.status = (phase_now == PH_JUMP) ? PH_SEND : phase_now;
    pending_results.push_back(r);
  endfunction

  // Compare one DUT result with the oldest prediction
  function void check_result(logic txv, logic [7:0] txb, logic [2:0] st);
    result_t e;
    if (pending_results.size() == 0) begin
      flag($sformatf("unexpected result tx_valid %0b tx_byte %02h status %0d", txv, txb, st));
      return;
    end
    e = pending_results.pop_front();
    if (txv !== e.tx_valid)
      flag($sformatf("tx_valid expected %0b got %0b", e.tx_valid, txv));
    if (txb !== e.tx_byte)
      flag($sformatf("tx_byte expected %02h got %02h", e.tx_byte, txb));
    if (st !== e.status)
      flag($sformatf("status expected %0d got %0d", e.status, st));
  endfunction
endclass

module serial_block_upload_engine_unit_tb;
  import sbue_pkg::*;

  // ops that the engine ignores in each phase, as masks indexed by op code
  localparam logic [3:0] NOISE_LOADING = (4'd1 << OP_RECV) | (4'd1 << OP_TIMEOUT)
                                       | (4'd1 << OP_SLOT);
  localparam logic [3:0] NOISE_SENDING = (4'd1 << OP_LOAD) | (4'd1 << OP_RECV)
                                       | (4'd1 << OP_TIMEOUT);
  localparam logic [3:0] NOISE_WAITING = (4'd1 << OP_LOAD) | (4'd1 << OP_SLOT);
  localparam logic [3:0] NOISE_ANY     = 4'hF;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] b;
  } reply_step_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               item_valid;
  logic               item_ready;
  logic [1:0]         operation;
  logic [7:0]         data_byte;
  logic               end_of_block;
  logic               end_of_file;
  logic               result_valid;
  logic               result_ready;
  logic               tx_valid;
  logic [7:0]         tx_byte;
  logic [2:0]         status;

  upload_scoreboard sb = new();
  bit               tx_gaps_on = 1;
  bit               rx_gaps_on = 1;
  reply_step_t      reply_q[$];

  serial_block_upload_engine_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: alternating ready bursts and stalls
  initial begin
    int run;
    run = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        if (result_ready || !rx_gaps_on) begin
          run = rx_gaps_on ? pick_gap() : 0;
          if (run > 0) begin
            result_ready = 1'b0;
          end else begin
            result_ready = 1'b1;
            run = $urandom_range(1, 8);
          end
        end else begin
          result_ready = 1'b1;
          run = $urandom_range(1, 12);
        end
      end
      run--;
    end
  end

  // Monitor: results are checked before the same-edge request is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) sb.check_result(tx_valid, tx_byte, status);
      if (item_valid && item_ready)
        sb.note_request(operation, data_byte, end_of_block, end_of_file);
    end
  end

  // Stimulus tasks are entered and left just after a falling edge
  task automatic push_request(input logic [1:0] op, input logic [7:0] b,
                              input logic eob, input logic eof);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    repeat (gap) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid   = 1'b1;
    operation    = op;
    data_byte    = b;
    end_of_block = eob;
    end_of_file  = eof;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // A request of a kind picked from mask, random payload
  task automatic noise_request(input logic [3:0] mask);
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    while (!mask[op]) op = 2'($urandom_range(0, 3));
    push_request(op, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Hold the sender until every result is in, then let the pipe settle
  task automatic wait_idle();
    item_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // APB write, then read back
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] held;
    logic [31:0] back;
    held    = (idx == REG_START_ADDRESS) ? value : {28'd0, value[3:0]};
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, held);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    back = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (back !== held)
      sb.flag($sformatf("register %0d read %08h, written %08h", idx, back, held));
  endtask

  // First rounds hit the extremes, later ones are random
  task automatic reconfigure(input int round);
    logic [31:0] sa;
    logic [3:0]  br;
    logic [3:0]  cr;
    case (round)
      0: begin sa = 32'hFFFF_FFFC; br = 4'd15; cr = 4'd0;  end
      1: begin sa = 32'h0000_0000; br = 4'd1;  cr = 4'd1;  end
      2: begin sa = 32'hFFFF_FFFF; br = 4'd0;  cr = 4'd15; end
      default: begin
        case ($urandom_range(0, 3))
          0:       sa = 32'h0000_0000;
          1:       sa = 32'hFFFF_FFFF;
          default: sa = $urandom;
        endcase
        br = 4'($urandom);
        cr = 4'($urandom);
      end
    endcase
    wait_idle();
    write_reg(REG_START_ADDRESS, sa);
    write_reg(REG_BLOCK_RETRIES, {28'($urandom), br});
    write_reg(REG_CRC_RETRIES, {28'($urandom), cr});
  endtask

  initial begin
    int          k;
    int          r;
    int          n;
    int          useful_items;
    int          item_goal;
    int          blk_target;
    int          blocks;
    int          cfg_round;
    bit          full_blk;
    bit          final_now;
    bit          end_fail;
    bit          last;
    bit          may_fail;
    logic        eob;
    logic        eof;
    logic [31:0] word;
    reply_step_t step;

    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    item_valid   = 1'b0;
    operation    = OP_LOAD;
    data_byte    = 8'h00;
    end_of_block = 1'b0;
    end_of_file  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: stray ops, a two-byte block at reset settings, busy load, idle slots
    push_request(OP_SLOT, 8'h00, 1'b0, 1'b0);
    push_request(OP_RECV, 8'hFF, 1'b1, 1'b1);
    push_request(OP_TIMEOUT, 8'h00, 1'b0, 1'b0);
    push_request(OP_LOAD, 8'hFF, 1'b0, 1'b0);
    push_request(OP_LOAD, 8'h00, 1'b1, 1'b0);
    push_request(OP_LOAD, 8'h5A, 1'b1, 1'b1);
    while (sb.phase_now == PH_SEND) push_request(OP_SLOT, 8'hFF, 1'b1, 1'b1);
    push_request(OP_SLOT, 8'h00, 1'b0, 1'b0);
    for (k = 0; k < 4; k++) push_request(OP_RECV, sb.msb_byte(sb.block_sum, k), 1'b0, 1'b0);
    push_request(OP_SLOT, 8'h00, 1'b0, 1'b0);
    reconfigure(0);

    // Random program: well-formed blocks with random replies and ignored noise
    useful_items = 0;
    item_goal    = 700;
    blk_target   = 0;
    blocks       = 0;
    cfg_round    = 1;
    full_blk     = 0;
    final_now    = 0;
    end_fail     = 1'($urandom_range(0, 1));
    while (sb.phase_now != PH_FAIL && sb.phase_now != PH_DONE) begin
      if (sb.phase_now == PH_LOAD || sb.phase_now == PH_ACCEPT) begin
        if (blk_target == 0) begin
          final_now = (useful_items >= item_goal);
          if (blocks % 2 == 1 && !final_now) begin
            reconfigure(cfg_round);
            cfg_round++;
          end
          tx_gaps_on = ($urandom_range(0, 4) != 0);
          rx_gaps_on = ($urandom_range(0, 4) != 0);
          full_blk   = (blocks == 2);
          r = $urandom_range(0, 99);
          if (full_blk) begin
            blk_target = BLOCK_BYTES;
          end else if (r < 70) begin
            blk_target = $urandom_range(1, 6);
          end else if (r < 95) begin
            blk_target = $urandom_range(7, 24);
          end else begin
            blk_target = $urandom_range(25, 64);
          end
          blocks++;
        end
        if ($urandom_range(0, 9) == 0) begin
          noise_request(NOISE_LOADING);
        end else begin
          last = (sb.fill_cnt + 1 >= blk_target);
          // a full block closes on its own, without end_of_block
          if (!last || full_blk) begin
            eob = 1'b0;
            eof = 1'b0;
          end else if (final_now && !end_fail) begin
            eob = 1'($urandom);
            eof = 1'b1;
          end else if (final_now) begin
            eob = 1'b1;
            eof = 1'($urandom);
          end else begin
            eob = 1'b1;
            eof = 1'b0;
          end
          push_request(OP_LOAD, 8'($urandom), eob, eof);
          useful_items++;
          if (last) blk_target = 0;
        end
      end else if (sb.phase_now == PH_SEND || sb.phase_now == PH_JUMP) begin
        if ($urandom_range(0, 9) == 0) begin
          noise_request(NOISE_SENDING);
        end else begin
          push_request(OP_SLOT, 8'($urandom), 1'($urandom), 1'($urandom));
          useful_items++;
        end
      end else begin
        // awaiting checksum: plan a reply when the wait begins
        if (reply_q.size() == 0) begin
          may_fail = (sb.block_tries > 1) || (end_fail && final_now);
          r = (end_fail && final_now) ? $urandom_range(60, 99) : $urandom_range(0, 99);
          if (r >= 80 && (sb.crc_tries > 1 || may_fail)) begin
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++) reply_q.push_back('{OP_RECV, 8'($urandom)});
            reply_q.push_back('{OP_TIMEOUT, 8'($urandom)});
          end else begin
            word = sb.block_sum;
            if (r >= 60 && may_fail)
              word = word ^ (($urandom_range(0, 1) != 0) ? (32'd1 << $urandom_range(0, 31))
                                                         : ($urandom | 32'd1));
            for (k = 0; k < 4; k++) reply_q.push_back('{OP_RECV, sb.msb_byte(word, k)});
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          noise_request(NOISE_WAITING);
        end else begin
          step = reply_q.pop_front();
          push_request(step.op, step.b, 1'($urandom), 1'($urandom));
          useful_items++;
        end
      end
    end

    // Terminal state: everything is ignored from here on
    repeat (20) noise_request(NOISE_ANY);

    wait_idle();
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Run limit
  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
rtl/sbue_pkg.sv
rtl/sbue_ram.sv
rtl/sbue_regs.sv
rtl/sbue_ctrl.sv
rtl/sbue_outq.sv
rtl/serial_block_upload_engine_unit.sv
rtl/sbue_checker.sv
test/serial_block_upload_engine_unit_tb.sv
